// ===== design/bnp_pkg.sv =====
// Shared constants and helpers for the bump normal perturbation pipeline.
package bnp_pkg;

  localparam int unsigned VecW = 64;
  localparam int unsigned MagW = 31;
  localparam int unsigned SqrtSteps = 32;
  localparam logic [15:0] StrengthReset = 16'd256;

  // Pipeline depth of bnp_norm, from an input beat to its result.
  function automatic int unsigned norm_lat(input int unsigned frac);
    return frac + 39;
  endfunction

endpackage

// ===== design/bump_normal_perturb.sv =====
// Bump normal perturbation: one item per cycle through a stall-together pipeline.
// The block accepts one beat per clock while the output is not stalled and returns one
// result beat per input beat, in order. Its depth is set by three normalizers in series,
// each a 32-step square root followed by a NORMAL_FRAC_BITS+1 step divider; a stall on
// the output holds the whole pipeline.
// The strength register is sampled when a beat enters and may be rewritten only
// while the pipeline is empty.
module bump_normal_perturb #(
  parameter int unsigned NORMAL_FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic [15:0]        height_left_i,
  input  logic [15:0]        height_right_i,
  input  logic [15:0]        height_down_i,
  input  logic [15:0]        height_up_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] world_x_o,
  output logic signed [15:0] world_y_o,
  output logic signed [15:0] world_z_o,
  output logic               degenerate_o
);

  localparam int unsigned F = NORMAL_FRAC_BITS;
  localparam int unsigned OW = F + 2;
  localparam int unsigned VW = bnp_pkg::VecW;
  localparam int unsigned NL = bnp_pkg::norm_lat(F);
  localparam int unsigned PW = 16 + OW;
  localparam int unsigned MulW = (OW > 16) ? 2 * OW : 16 + OW;
  localparam int unsigned SumW = MulW + 2;
  localparam int unsigned BunW = 48 + 6 * OW;

  logic                  en;
  logic [15:0]           strength_q;
  logic signed [16:0]    dx, dy, nx17, ny17, nz17;
  logic [16:0]           ax, ay;
  logic signed [33:0]    tsx, tsy;
  logic signed [16:0]    tv_d [3];
  logic                  s0_vld_q;
  logic [2:0][VW-1:0]    s0_tsv_q, s0_tv_q;
  logic [2:0][15:0]      s0_n_q;
  logic [2:0][OW-1:0]    ts_vec, t_vec, b_vec, w_vec, t2, ts2;
  logic                  t_vld, b_vld, b_ok, w_vld, w_ok, ok_d2;
  logic [47:0]           n1_flat;
  logic [2:0][15:0]      n1, n2;
  logic [BunW-1:0]       bun_in, bun_out;
  logic signed [PW-1:0]  p1_q [6];
  logic                  p1_vld_q, p2_vld_q;
  logic [2:0][VW-1:0]    p2_cv_q;
  logic signed [MulW-1:0] w1_q [3][3];
  logic                  w1_vld_q, w1_ok_q, w2_vld_q, w2_ok_q;
  logic [2:0][VW-1:0]    w2_q;
  logic signed [VW-1:0]  wx, wy, wz;
  logic                  out_vld_q, out_deg_q;
  logic [15:0]           out_x_q, out_y_q, out_z_q;

  assign en = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q <= bnp_pkg::StrengthReset;
    end else if (cfg_we_i) begin
      strength_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    dx   = $signed({1'b0, height_right_i}) - $signed({1'b0, height_left_i});
    dy   = $signed({1'b0, height_up_i}) - $signed({1'b0, height_down_i});
    tsx  = $signed({1'b0, strength_q}) * dx;
    tsy  = $signed({1'b0, strength_q}) * dy;
    nx17 = 17'(normal_x_i);
    ny17 = 17'(normal_y_i);
    nz17 = 17'(normal_z_i);
    ax   = nx17[16] ? 17'(-nx17) : 17'(nx17);
    ay   = ny17[16] ? 17'(-ny17) : 17'(ny17);
    if (ax > ay) begin
      tv_d[0] = nz17;
      tv_d[1] = '0;
      tv_d[2] = -nx17;
    end else begin
      tv_d[0] = '0;
      tv_d[1] = -nz17;
      tv_d[2] = ny17;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_tsv_q[0] <= VW'(tsx);
      s0_tsv_q[1] <= VW'(tsy);
      s0_tsv_q[2] <= VW'(1) << 24;
      for (int i = 0; i < 3; i++) begin
        s0_tv_q[i] <= VW'(tv_d[i]);
      end
      s0_n_q[0] <= normal_x_i;
      s0_n_q[1] <= normal_y_i;
      s0_n_q[2] <= normal_z_i;
    end
  end

  bnp_norm #(.FracBits(F)) u_norm_ts (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s0_vld_q), .vec_i(s0_tsv_q),
    .valid_o(), .vec_o(ts_vec), .ok_o()
  );

  bnp_norm #(.FracBits(F)) u_norm_t (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s0_vld_q), .vec_i(s0_tv_q),
    .valid_o(t_vld), .vec_o(t_vec), .ok_o()
  );

  bnp_delay #(.Width(48), .Depth(NL)) u_dly_n (
    .clk_i, .en_i(en), .d_i(s0_n_q), .q_o(n1_flat)
  );
  assign n1 = n1_flat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q <= t_vld;
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q[0] <= $signed(n1[1]) * $signed(t_vec[2]);
      p1_q[1] <= $signed(n1[2]) * $signed(t_vec[1]);
      p1_q[2] <= $signed(n1[2]) * $signed(t_vec[0]);
      p1_q[3] <= $signed(n1[0]) * $signed(t_vec[2]);
      p1_q[4] <= $signed(n1[0]) * $signed(t_vec[1]);
      p1_q[5] <= $signed(n1[1]) * $signed(t_vec[0]);
      for (int i = 0; i < 3; i++) begin
        p2_cv_q[i] <= VW'(p1_q[2*i]) - VW'(p1_q[2*i+1]);
      end
    end
  end

  assign bun_in = {n1, t_vec, ts_vec};

  bnp_delay #(.Width(BunW), .Depth(NL + 2)) u_dly_frame (
    .clk_i, .en_i(en), .d_i(bun_in), .q_o(bun_out)
  );
  assign {n2, t2, ts2} = bun_out;

  bnp_norm #(.FracBits(F)) u_norm_b (
    .clk_i, .rst_ni, .en_i(en), .valid_i(p2_vld_q), .vec_i(p2_cv_q),
    .valid_o(b_vld), .vec_o(b_vec), .ok_o(b_ok)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_vld_q <= 1'b0;
      w2_vld_q <= 1'b0;
    end else if (en) begin
      w1_vld_q <= b_vld;
      w2_vld_q <= w1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        w1_q[i][0] <= $signed(t2[i]) * $signed(ts2[0]);
        w1_q[i][1] <= $signed(b_vec[i]) * $signed(ts2[1]);
        w1_q[i][2] <= $signed(n2[i]) * $signed(ts2[2]);
        w2_q[i] <= VW'(SumW'(w1_q[i][0]) + SumW'(w1_q[i][1]) + SumW'(w1_q[i][2]));
      end
      w1_ok_q <= b_ok;
      w2_ok_q <= w1_ok_q;
    end
  end

  bnp_norm #(.FracBits(F)) u_norm_w (
    .clk_i, .rst_ni, .en_i(en), .valid_i(w2_vld_q), .vec_i(w2_q),
    .valid_o(w_vld), .vec_o(w_vec), .ok_o(w_ok)
  );

  bnp_delay #(.Width(1), .Depth(NL)) u_dly_ok (
    .clk_i, .en_i(en), .d_i(w2_ok_q), .q_o(ok_d2)
  );

  assign wx = VW'($signed(w_vec[0]));
  assign wy = VW'($signed(w_vec[1]));
  assign wz = VW'($signed(w_vec[2]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= w_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (w_ok && ok_d2) begin
        out_x_q   <= wx[15:0];
        out_y_q   <= wy[15:0];
        out_z_q   <= wz[15:0];
        out_deg_q <= 1'b0;
      end else begin
        out_x_q   <= '0;
        out_y_q   <= '0;
        out_z_q   <= '0;
        out_deg_q <= 1'b1;
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign world_x_o    = out_x_q;
  assign world_y_o    = out_y_q;
  assign world_z_o    = out_z_q;
  assign degenerate_o = out_deg_q;

endmodule

// ===== design/bnp_delay.sv =====
// Enabled shift-register delay line for payload that rides beside a pipeline.
module bnp_delay #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [Width-1:0] d_i,
  output logic [Width-1:0] q_o
);

  logic [Width-1:0] tap_q [Depth];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < Depth; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[Depth-1];

endmodule

// ===== design/bnp_norm.sv =====
// Pipelined fixed-point 3-vector normalizer: range shift, square sum, root, divide.
module bnp_norm #(
  parameter int unsigned FracBits = 14
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [2:0][bnp_pkg::VecW-1:0]       vec_i,
  output logic                                valid_o,
  output logic [2:0][FracBits+1:0]            vec_o,
  output logic                                ok_o
);

  localparam int unsigned VW = bnp_pkg::VecW;
  localparam int unsigned MW = bnp_pkg::MagW;
  localparam int unsigned RW = bnp_pkg::SqrtSteps;
  localparam int unsigned QW = FracBits + 1;
  localparam int unsigned OW = FracBits + 2;
  localparam int unsigned DivSteps = FracBits + 1;
  localparam int unsigned ShW = $clog2(VW - MW + 1);
  localparam logic [QW-1:0] One = {1'b1, {FracBits{1'b0}}};

  typedef struct packed {
    logic [VW-1:0]        rem;
    logic [RW-1:0]        root;
    logic [2:0][MW-1:0]   mag;
    logic [2:0]           neg;
    logic                 zero;
  } sq_t;

  typedef struct packed {
    logic [2:0][VW-1:0]   rem;
    logic [2:0][QW-1:0]   quo;
    logic [RW-1:0]        len;
    logic [2:0]           neg;
    logic                 zero;
  } dv_t;

  logic [2:0][VW-1:0]   a_mag_d, a_mag_q;
  logic [2:0]           a_neg_d, a_neg_q;
  logic [VW-1:0]        a_max_d, a_max_q;
  logic                 a_vld_q;
  logic [ShW-1:0]       b_sh;
  logic [2:0][MW-1:0]   b_mag_d, b_mag_q;
  logic [2:0]           b_neg_q;
  logic                 b_vld_q;
  logic [2:0][2*MW-1:0] c_sq_q;
  logic [2:0][MW-1:0]   c_mag_q;
  logic [2:0]           c_neg_q;
  logic                 c_vld_q;
  logic [VW-1:0]        d_sum;
  sq_t                  sq_q [RW+1];
  logic                 sq_vld_q [RW+1];
  dv_t                  dv_d;
  dv_t                  dv_q [DivSteps+1];
  logic                 dv_vld_q [DivSteps+1];
  logic [2:0][OW-1:0]   o_vec_d, o_vec_q;
  logic                 o_ok_q, o_vld_q;

  always_comb begin
    a_max_d = '0;
    for (int i = 0; i < 3; i++) begin
      a_neg_d[i] = vec_i[i][VW-1];
      a_mag_d[i] = a_neg_d[i] ? (~vec_i[i] + VW'(1)) : vec_i[i];
      if (a_mag_d[i] > a_max_d) begin
        a_max_d = a_mag_d[i];
      end
    end
  end

  always_comb begin
    b_sh = '0;
    for (int k = MW; k < VW; k++) begin
      if (a_max_q[k]) begin
        b_sh = ShW'(k - MW + 1);
      end
    end
    for (int i = 0; i < 3; i++) begin
      b_mag_d[i] = MW'(a_mag_q[i] >> b_sh);
    end
  end

  assign d_sum = VW'(c_sq_q[0]) + VW'(c_sq_q[1]) + VW'(c_sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q     <= 1'b0;
      b_vld_q     <= 1'b0;
      c_vld_q     <= 1'b0;
      sq_vld_q[0] <= 1'b0;
    end else if (en_i) begin
      a_vld_q     <= valid_i;
      b_vld_q     <= a_vld_q;
      c_vld_q     <= b_vld_q;
      sq_vld_q[0] <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_mag_q <= a_mag_d;
      a_neg_q <= a_neg_d;
      a_max_q <= a_max_d;
      b_mag_q <= b_mag_d;
      b_neg_q <= a_neg_q;
      for (int i = 0; i < 3; i++) begin
        c_sq_q[i] <= b_mag_q[i] * b_mag_q[i];
      end
      c_mag_q       <= b_mag_q;
      c_neg_q       <= b_neg_q;
      sq_q[0].rem   <= d_sum;
      sq_q[0].root  <= '0;
      sq_q[0].mag   <= c_mag_q;
      sq_q[0].neg   <= c_neg_q;
      sq_q[0].zero  <= (d_sum == '0);
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam int unsigned Bit = RW - 1 - k;
    logic [VW-1:0] inc;
    sq_t           nxt;

    always_comb begin
      nxt = sq_q[k];
      inc = (VW'(sq_q[k].root) << (Bit + 1)) + (VW'(1) << (2 * Bit));
      if (sq_q[k].rem >= inc) begin
        nxt.rem  = sq_q[k].rem - inc;
        nxt.root = sq_q[k].root | (RW'(1) << Bit);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        sq_vld_q[k+1] <= sq_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[k+1] <= nxt;
      end
    end
  end

  always_comb begin
    dv_d.len  = sq_q[RW].root;
    dv_d.neg  = sq_q[RW].neg;
    dv_d.zero = sq_q[RW].zero;
    dv_d.quo  = '0;
    for (int i = 0; i < 3; i++) begin
      dv_d.rem[i] = (VW'(sq_q[RW].mag[i]) << FracBits) + VW'(sq_q[RW].root >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_vld_q[0] <= sq_vld_q[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q[0] <= dv_d;
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    localparam int unsigned Bit = DivSteps - 1 - k;
    logic [VW-1:0] trial;
    dv_t           nxt;

    always_comb begin
      nxt   = dv_q[k];
      trial = VW'(dv_q[k].len) << Bit;
      for (int i = 0; i < 3; i++) begin
        if (dv_q[k].rem[i] >= trial) begin
          nxt.rem[i] = dv_q[k].rem[i] - trial;
          nxt.quo[i] = dv_q[k].quo[i] | (QW'(1) << Bit);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[k+1] <= nxt;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [QW-1:0] q;
      q = dv_q[DivSteps].quo[i];
      if (q > One) begin
        q = One;
      end
      if (dv_q[DivSteps].zero) begin
        o_vec_d[i] = '0;
      end else if (dv_q[DivSteps].neg[i]) begin
        o_vec_d[i] = ~OW'(q) + OW'(1);
      end else begin
        o_vec_d[i] = OW'(q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (en_i) begin
      o_vld_q <= dv_vld_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o_vec_q <= o_vec_d;
      o_ok_q  <= !dv_q[DivSteps].zero;
    end
  end

  assign valid_o = o_vld_q;
  assign vec_o   = o_vec_q;
  assign ok_o    = o_ok_q;

endmodule

// ===== design/bnp_checker.sv =====
// Port-level checks for bump_normal_perturb and the bind that attaches them.
module bnp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] world_x_o,
  input logic signed [15:0] world_y_o,
  input logic signed [15:0] world_z_o,
  input logic               degenerate_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Result beat dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(world_x_o) && $stable(world_y_o)
      && $stable(world_z_o) && $stable(degenerate_o))
    else $error("Result beat changed while stalled.");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("Input refused although the output is free.");

  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> world_x_o == 16'sd0 && world_y_o == 16'sd0
      && world_z_o == 16'sd0)
    else $error("Degenerate beat carries a nonzero normal.");

endmodule

bind bump_normal_perturb bnp_checker u_bnp_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .world_x_o(world_x_o),
  .world_y_o(world_y_o),
  .world_z_o(world_z_o),
  .degenerate_o(degenerate_o)
);

// ===== verif/bnp_checker.sv =====
// Checker for the bump normal perturbation block: predicts and compares result beats.
`timescale 1ns / 100ps
module bnp_tb_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic [15:0]        height_left_i,
  input  logic [15:0]        height_right_i,
  input  logic [15:0]        height_down_i,
  input  logic [15:0]        height_up_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [15:0] world_x_i,
  input  logic signed [15:0] world_y_i,
  input  logic signed [15:0] world_z_i,
  input  logic               degenerate_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  localparam int unsigned FracBits = 14;
  localparam logic [15:0] StrengthReset = 16'd256;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               degen;
  } normal_t;

  logic [15:0] strength_q;
  normal_t     normal_queue[$];

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit unit_vec(input longint v[3], output longint o[3]);
    logic [63:0] mag[3];
    logic [63:0] m;
    logic [63:0] acc;
    logic [63:0] len;
    logic [63:0] q;
    int          s;
    m = 0;
    acc = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? 64'd0 - 64'(v[i]) : 64'(v[i]);
      if (mag[i] > m) m = mag[i];
    end
    while ((m >> s) >= (64'd1 << 31)) s++;
    for (int i = 0; i < 3; i++) begin
      mag[i] = mag[i] >> s;
      acc = acc + mag[i] * mag[i];
    end
    if (acc == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return 0;
    end
    len = int_sqrt(acc);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FracBits) + len / 2) / len;
      if (q > (64'd1 << FracBits)) q = 64'd1 << FracBits;
      o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic normal_t predict_world(input longint nx, input longint ny,
                                            input longint nz, input longint hl,
                                            input longint hr, input longint hd,
                                            input longint hu, input longint str);
    longint  n[3], v[3], ts[3], t[3], b[3], w[3];
    bit      ok;
    normal_t r;
    n[0] = nx;
    n[1] = ny;
    n[2] = nz;
    v[0] = str * (hr - hl);
    v[1] = str * (hu - hd);
    v[2] = 64'sd1 << 24;
    ok = unit_vec(v, ts);
    if ((nx < 0 ? -nx : nx) > (ny < 0 ? -ny : ny)) begin
      v[0] = nz;
      v[1] = 0;
      v[2] = -nx;
    end else begin
      v[0] = 0;
      v[1] = -nz;
      v[2] = ny;
    end
    ok = unit_vec(v, t);
    if (ok) begin
      v[0] = n[1] * t[2] - n[2] * t[1];
      v[1] = n[2] * t[0] - n[0] * t[2];
      v[2] = n[0] * t[1] - n[1] * t[0];
      ok = unit_vec(v, b);
    end
    if (ok) begin
      for (int i = 0; i < 3; i++) v[i] = t[i] * ts[0] + b[i] * ts[1] + n[i] * ts[2];
      ok = unit_vec(v, w);
    end
    if (!ok) begin
      r = '{x: '0, y: '0, z: '0, degen: 1'b1};
    end else begin
      r = '{x: 16'(w[0]), y: 16'(w[1]), z: 16'(w[2]), degen: 1'b0};
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    normal_t e;
    if (!rst_ni) begin
      strength_q <= StrengthReset;
    end else begin
      if (cfg_we_i) strength_q <= cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        normal_queue.push_back(predict_world(normal_x_i, normal_y_i, normal_z_i,
          height_left_i, height_right_i, height_down_i, height_up_i, strength_q));
      end
      if (out_valid_i && out_ready_i) begin
        if (normal_queue.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          e = normal_queue.pop_front();
          if (world_x_i !== e.x) report_mismatch("world_x", world_x_i, e.x);
          if (world_y_i !== e.y) report_mismatch("world_y", world_y_i, e.y);
          if (world_z_i !== e.z) report_mismatch("world_z", world_z_i, e.z);
          if (degenerate_i !== e.degen) report_mismatch("degenerate", degenerate_i, e.degen);
        end
      end
    end
    pending_o = normal_queue.size();
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the bump normal perturbation block: stimulus and verdict.
`timescale 1ns / 100ps
module tb;

  localparam int unsigned Latency = 3 * bnp_pkg::norm_lat(14) + 6;
  localparam int NumRandom = 450;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [15:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] normal_x_i = '0;
  logic signed [15:0] normal_y_i = '0;
  logic signed [15:0] normal_z_i = '0;
  logic [15:0]        height_left_i = '0;
  logic [15:0]        height_right_i = '0;
  logic [15:0]        height_down_i = '0;
  logic [15:0]        height_up_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] world_x_o;
  logic signed [15:0] world_y_o;
  logic signed [15:0] world_z_o;
  logic               degenerate_o;
  int                 fail_count;
  int                 pending;
  bit                 sending_done = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bump_normal_perturb i_dut (.*);

  bnp_tb_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_i(in_ready_o),
    .normal_x_i, .normal_y_i, .normal_z_i, .height_left_i, .height_right_i,
    .height_down_i, .height_up_i, .out_valid_i(out_valid_o), .out_ready_i,
    .world_x_i(world_x_o), .world_y_i(world_y_o), .world_z_i(world_z_o),
    .degenerate_i(degenerate_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'($signed($urandom_range(0, 32768)) - 16384);
      1: return 16'($urandom_range(0, 600) - 300);
      2: return 16'sd16384;
      3: return -16'sd16384;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_beat(input logic [15:0] nx, input logic [15:0] ny, input logic [15:0] nz,
                           input logic [15:0] hl, input logic [15:0] hr,
                           input logic [15:0] hd, input logic [15:0] hu);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    normal_x_i <= nx;
    normal_y_i <= ny;
    normal_z_i <= nz;
    height_left_i <= hl;
    height_right_i <= hr;
    height_down_i <= hd;
    height_up_i <= hu;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_strength(input logic [15:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int wait_cycles;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i || !out_ready_i) begin
        if (wait_cycles > 0) begin
          out_ready_i <= 1'b0;
          wait_cycles--;
        end else begin
          out_ready_i <= 1'b1;
          if (out_valid_o && out_ready_i) begin
            wait_cycles = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
            if (wait_cycles > 0) out_ready_i <= 1'b0;
          end
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_beat(16'sd16384, 16'sd0, 16'sd0, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
    send_beat(16'sd0, 16'sd16384, 16'sd0, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    send_beat(16'sd0, 16'sd0, 16'sd16384, 16'h1234, 16'h1234, 16'h8000, 16'h8000);
    send_beat(16'sd0, 16'sd0, 16'sd0, 16'h0000, 16'h1000, 16'h0000, 16'h2000);
    send_beat(-16'sd16384, -16'sd16384, -16'sd16384, 16'hFFFF, 16'h0, 16'hFFFF, 16'h0);
    send_beat(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0);
    send_beat(16'h8000, 16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
    send_beat(16'sd100, 16'sd100, 16'sd0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_beat(16'sd0, 16'sd0, 16'sd500, 16'h0, 16'h0, 16'h0, 16'h0);
    write_strength(16'hFFFF);
    send_beat(16'sd0, 16'sd0, 16'sd16384, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_beat(16'sd9000, -16'sd4000, 16'sd12000, 16'h0, 16'hFFFF, 16'h0, 16'hFFFF);
    write_strength(16'h0000);
    send_beat(16'sd0, 16'sd16384, 16'sd0, 16'h0, 16'hFFFF, 16'h0, 16'hFFFF);
    send_beat(16'sd3, -16'sd7, 16'sd16000, 16'h1, 16'h2, 16'h3, 16'h4);
    for (int phase = 0; phase < 4; phase++) begin
      write_strength(phase == 0 ? 16'd256 : phase == 3 ? 16'hFFFF : 16'($urandom));
      for (int k = 0; k < NumRandom / 4; k++) begin
        send_beat(rand_comp(), rand_comp(), rand_comp(), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
      end
    end
    in_valid_i <= 1'b0;
    sending_done = 1;
  end

  initial begin
    wait (sending_done);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end
endmodule
